// ===== hw/rtl/transposition_table_probe_store_defines.svh =====
// ---------------------------------------------------------------------------
// Transposition table probe/store: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_DEFINES_SVH

// same-cycle implication
`define TTPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ttps_pkg.sv =====
// ---------------------------------------------------------------------------
// Transposition table probe/store: package
// Field widths, bound and request codes, and the structs shared by modules.
// ---------------------------------------------------------------------------
package ttps_pkg;

  localparam int KEY_W   = 64;
  localparam int DEPTH_W = 8;
  localparam int SCORE_W = 16;
  localparam int BOUND_W = 2;
  localparam int MOVE_W  = 24;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [BOUND_W-1:0]        bound;
  } entry_t;

  typedef struct packed {
    logic                      kind;
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;
  } req_t;

  typedef struct packed {
    logic                      key_matched;
    logic                      usable;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
  } res_t;

  typedef struct packed {
    logic wr_en;
    logic move_wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== hw/rtl/ttps_slot_index.sv =====
// ---------------------------------------------------------------------------
// Transposition table probe/store: slot index unit
// Key modulo table size. Power-of-two sizes register the low bits of the key;
// other sizes reduce the key four bits a cycle by compare and subtract
// against constant multiples of the table size.
// ---------------------------------------------------------------------------
module ttps_slot_index #(
  parameter int ENTRIES = 4096,
  parameter int IDX_W   = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ttps_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [IDX_W-1:0]          idx
);
  import ttps_pkg::*;

  generate
    if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_mask
      logic             done_r;
      logic [IDX_W-1:0] idx_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          idx_r <= key[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign idx  = idx_r;
    end else begin : g_serial
      localparam int DIG_W   = 4;
      localparam int STEPS   = KEY_W / DIG_W;
      localparam int CNT_W   = $clog2(STEPS);
      localparam int TRIAL_W = IDX_W + DIG_W;
      localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

      logic               busy_r, busy_nxt;
      logic               done_r, done_nxt;
      logic [CNT_W-1:0]   cnt_r, cnt_nxt;
      logic [KEY_W-1:0]   key_r, key_nxt;
      logic [IDX_W-1:0]   rem_r, rem_nxt;
      logic [TRIAL_W-1:0] trial;
      logic [TRIAL_W-1:0] sub;

      // shift in one key digit, take off the largest multiple that fits
      always_comb begin
        trial    = {rem_r, key_r[KEY_W-1 -: DIG_W]};
        sub      = '0;
        for (int k = 1; k < (1 << DIG_W); k++) begin
          if (trial >= TRIAL_W'(k * ENTRIES)) begin
            sub = TRIAL_W'(k * ENTRIES);
          end
        end
        busy_nxt = busy_r;
        done_nxt = 1'b0;
        cnt_nxt  = cnt_r;
        key_nxt  = key_r;
        rem_nxt  = rem_r;
        if (start) begin
          busy_nxt = 1'b1;
          cnt_nxt  = '0;
          key_nxt  = key;
          rem_nxt  = '0;
        end else if (busy_r) begin
          key_nxt = {key_r[KEY_W-DIG_W-1:0], {DIG_W{1'b0}}};
          cnt_nxt = cnt_r + 1'b1;
          rem_nxt = IDX_W'(trial - sub);
          if (cnt_r == LAST_STEP) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          busy_r <= busy_nxt;
          done_r <= done_nxt;
        end
      end

      always_ff @(posedge clk) begin
        cnt_r <= cnt_nxt;
        key_r <= key_nxt;
        rem_r <= rem_nxt;
      end

      assign done = done_r;
      assign idx  = rem_r;
    end
  endgenerate

endmodule

// ===== hw/rtl/ttps_slot_mem.sv =====
// ---------------------------------------------------------------------------
// Transposition table probe/store: slot memories
// Entry memory (key, score, depth, bound) and a separate move memory so a
// store can leave the move alone. One access per cycle, registered read.
// ---------------------------------------------------------------------------
module ttps_slot_mem #(
  parameter int ENTRIES = 4096,
  parameter int IDX_W   = 12
) (
  input  logic                        clk,
  input  ttps_pkg::mem_ctl_t          ctl,
  input  logic [IDX_W-1:0]            addr,
  input  ttps_pkg::entry_t            wr_entry,
  input  logic [ttps_pkg::MOVE_W-1:0] wr_move,
  output ttps_pkg::entry_t            rd_entry,
  output logic [ttps_pkg::MOVE_W-1:0] rd_move
);
  import ttps_pkg::*;

  entry_t            entry_mem [ENTRIES];
  logic [MOVE_W-1:0] move_mem  [ENTRIES];
  entry_t            rd_entry_r;
  logic [MOVE_W-1:0] rd_move_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_mem[addr] <= wr_entry;
    end
    if (ctl.rd_en) begin
      rd_entry_r <= entry_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.move_wr_en) begin
      move_mem[addr] <= wr_move;
    end
    if (ctl.rd_en) begin
      rd_move_r <= move_mem[addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_move  = rd_move_r;

endmodule

// ===== hw/rtl/ttps_bound_eval.sv =====
// ---------------------------------------------------------------------------
// Transposition table probe/store: probe evaluation
// Key compare, depth check and the alpha-beta bound rule on a slot read.
// ---------------------------------------------------------------------------
module ttps_bound_eval (
  input  ttps_pkg::req_t              req,
  input  ttps_pkg::entry_t            entry,
  input  logic [ttps_pkg::MOVE_W-1:0] move,
  output ttps_pkg::res_t              res
);
  import ttps_pkg::*;

  always_comb begin
    res = '0;
    if (req.kind == KIND_PROBE && entry.key == req.key) begin
      res.key_matched = 1'b1;
      res.move        = move;
      if (entry.depth >= req.depth) begin
        case (entry.bound)
          BOUND_EXACT: begin
            res.usable = 1'b1;
            res.score  = entry.score;
          end
          BOUND_UPPER: begin
            if (entry.score <= req.alpha) begin
              res.usable = 1'b1;
              res.score  = req.alpha;
            end
          end
          BOUND_LOWER: begin
            if (entry.score >= req.beta) begin
              res.usable = 1'b1;
              res.score  = req.beta;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/transposition_table_probe_store.sv =====
// ---------------------------------------------------------------------------
// Transposition table probe/store: top level
// Direct-mapped, always-replace table of search results with probe and store.
//
//   port    dir  words
//   in_*    in   probe or store request: kind, key, depth, score, bound,
//                move, alpha, beta
//   out_*   out  one result per request: match, usable, score, move
//
// Each word passes slot index, memory access and result register in turn, and
// the next word is taken only once the result register is loaded. Other sizes
// get the slot index from the remainder, which takes four key bits a cycle.
// After reset a clearing pass writes zeros over all TABLE_ENTRIES slots, one
// a cycle; no word is taken until it ends.
// A waiting result does not block the next word; a second result waits in
// the read stage while out_ready is low.
// ---------------------------------------------------------------------------
`include "transposition_table_probe_store_defines.svh"

module transposition_table_probe_store #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [ttps_pkg::KEY_W-1:0]          in_position_key,
  input  logic [ttps_pkg::DEPTH_W-1:0]        in_search_depth,
  input  logic signed [ttps_pkg::SCORE_W-1:0] in_store_score,
  input  logic [ttps_pkg::BOUND_W-1:0]        in_bound_flag,
  input  logic [ttps_pkg::MOVE_W-1:0]         in_best_move,
  input  logic signed [ttps_pkg::SCORE_W-1:0] in_alpha,
  input  logic signed [ttps_pkg::SCORE_W-1:0] in_beta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_key_matched,
  output logic                                out_usable,
  output logic signed [ttps_pkg::SCORE_W-1:0] out_score_out,
  output logic [ttps_pkg::MOVE_W-1:0]         out_move_out
);
  import ttps_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_INDEX = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  req_t              req_r;
  res_t              out_res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_accept;
  logic              out_load;
  logic              idx_done;
  logic [IDX_W-1:0]  idx;
  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  mem_addr;
  entry_t            wr_entry;
  logic [MOVE_W-1:0] wr_move;
  entry_t            rd_entry;
  logic [MOVE_W-1:0] rd_move;
  res_t              eval_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  ttps_slot_index #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_index (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .key   (in_position_key),
    .done  (idx_done),
    .idx   (idx)
  );

  // clearing pass writes zeros; stores write the request
  always_comb begin
    mem_ctl  = '0;
    mem_addr = idx;
    wr_entry = '0;
    wr_move  = '0;
    if (state_r == ST_CLEAR) begin
      mem_ctl.wr_en      = 1'b1;
      mem_ctl.move_wr_en = 1'b1;
      mem_addr           = clr_cnt_r;
    end else if (state_r == ST_INDEX && idx_done) begin
      wr_entry.key       = req_r.key;
      wr_entry.score     = req_r.score;
      wr_entry.depth     = req_r.depth;
      wr_entry.bound     = req_r.bound;
      wr_move            = req_r.move;
      mem_ctl.wr_en      = (req_r.kind == KIND_STORE);
      mem_ctl.move_wr_en = (req_r.kind == KIND_STORE) && (req_r.move != '0);
      mem_ctl.rd_en      = (req_r.kind == KIND_PROBE);
    end
  end

  ttps_slot_mem #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk      (clk),
    .ctl      (mem_ctl),
    .addr     (mem_addr),
    .wr_entry (wr_entry),
    .wr_move  (wr_move),
    .rd_entry (rd_entry),
    .rd_move  (rd_move)
  );

  ttps_bound_eval u_eval (
    .req   (req_r),
    .entry (rd_entry),
    .move  (rd_move),
    .res   (eval_res)
  );

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_INDEX;
        end
      end
      ST_INDEX: begin
        if (idx_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r.kind  <= in_kind;
      req_r.key   <= in_position_key;
      req_r.depth <= in_search_depth;
      req_r.score <= in_store_score;
      req_r.bound <= in_bound_flag;
      req_r.move  <= in_best_move;
      req_r.alpha <= in_alpha;
      req_r.beta  <= in_beta;
    end
    if (out_load) begin
      out_res_r <= eval_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_matched = out_res_r.key_matched;
  assign out_usable      = out_res_r.usable;
  assign out_score_out   = out_res_r.score;
  assign out_move_out    = out_res_r.move;

  `TTPS_ASSERT_SAME(a_idx_done_in_index, idx_done, state_r == ST_INDEX,
    "slot index finished outside the index state")
  `TTPS_ASSERT_NEXT(a_clear_ends, (state_r == ST_CLEAR) && (clr_cnt_r == LAST_IDX),
    state_r == ST_IDLE, "clearing pass did not end at the last slot")
  `TTPS_ASSERT_NEXT(a_store_result_zero, out_load && (req_r.kind == KIND_STORE),
    out_res_r == res_t'('0), "store word produced a non-zero result")
  `TTPS_ASSERT_SAME(a_usable_needs_match, out_valid_r && out_res_r.usable,
    out_res_r.key_matched, "usable result without a key match")

endmodule
